@@ sv/cau_pkg.sv @@
// shared types, constants and helpers of the complex arithmetic unit
// no dependencies
package cau_pkg;

    localparam int CAU_FRAC_BITS = 16;
    localparam int CAU_DIV_STEPS = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_SAT = 2'd1,
        ST_DZ  = 2'd2
    } t_status;

    // one divider step for one part
    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] q;
        logic [31:0] nlo;
    } t_div_part;

    // word as it moves through the divider stages
    typedef struct packed {
        t_op         op;
        logic        dz;
        logic        sat;
        logic [31:0] res_re;
        logic [31:0] res_im;
        logic        neg_re;
        logic        neg_im;
        logic        big_re;
        logic        big_im;
        logic [63:0] den;
        t_div_part   dre;
        t_div_part   dim;
    } t_stage;

    // sign and magnitude to saturated 32 bits, msb of result is the sat flag
    function automatic logic [32:0] f_pack(input logic neg, input logic [63:0] mag);
        logic [32:0] r;
        if (!neg) begin
            if (mag > 64'h0000_0000_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
            else r = {1'b0, mag[31:0]};
        end else begin
            if (mag > 64'h0000_0000_8000_0000) r = {1'b1, 32'h8000_0000};
            else r = {1'b0, 32'd0 - mag[31:0]};
        end
        return r;
    endfunction

endpackage

@@ sv/cau_if.sv @@
// request and response channels of the complex arithmetic unit
// depends on cau_pkg
interface cau_req_if;
    import cau_pkg::*;
    logic              valid;
    logic              ready;
    t_op               req_type;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
    modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic [1:0]        status;
    modport source (output valid, res_re, res_im, status, input ready);
    modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

@@ sv/cau_div_step.sv @@
// one restoring divide step on both parts of a quotient
// depends on cau_pkg
module cau_div_step
    import cau_pkg::*;
(
    input  logic [63:0] i_den,
    input  t_div_part   i_re,
    input  t_div_part   i_im,
    output t_div_part   o_re,
    output t_div_part   o_im
);

    logic [64:0] w_tre;
    logic [64:0] w_tim;
    logic        w_ge_re;
    logic        w_ge_im;
    logic [64:0] w_dre;
    logic [64:0] w_dim;

    always_comb begin
        w_tre   = {i_re.rem, i_re.nlo[31]};
        w_tim   = {i_im.rem, i_im.nlo[31]};
        w_ge_re = w_tre >= {1'b0, i_den};
        w_ge_im = w_tim >= {1'b0, i_den};
        w_dre   = w_ge_re ? w_tre - {1'b0, i_den} : w_tre;
        w_dim   = w_ge_im ? w_tim - {1'b0, i_den} : w_tim;
        o_re.rem = w_dre[63:0];
        o_im.rem = w_dim[63:0];
        o_re.q   = {i_re.q[30:0], w_ge_re};
        o_im.q   = {i_im.q[30:0], w_ge_im};
        o_re.nlo = {i_re.nlo[30:0], 1'b0};
        o_im.nlo = {i_im.nlo[30:0], 1'b0};
    end

endmodule

@@ sv/complex_arithmetic_unit.sv @@
// complex add, subtract, multiply and divide on signed fixed point operands
// depends on cau_pkg, cau_if, cau_div_step
//
// channel   dir  fields
// i_req     in   req_type, a_re, a_im, b_re, b_im
// o_rsp     out  res_re, res_im, status
//
// one word per cycle while the output is not stalled; every operation passes through all stages
// stages: multiply, sum, magnitude, scale and range check, 32 divide steps, output
// the divider takes one quotient bit per stage, which sets the depth
// reset clears all valid bits; a stalled output holds the whole pipeline
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = CAU_FRAC_BITS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cau_req_if.sink   i_req,
    cau_rsp_if.source o_rsp
);

    localparam int SH = 32 - FRAC_BITS;

    logic w_en;

    // stage 1
    logic               r1_v;
    t_op                r1_op;
    logic signed [63:0] r1_prr, r1_pii, r1_pri, r1_pir;
    logic [63:0]        r1_brr, r1_bii;
    logic signed [32:0] r1_as_re, r1_as_im;
    // stage 2
    logic               r2_v;
    t_op                r2_op;
    logic signed [64:0] r2_s_re, r2_s_im;
    logic [63:0]        r2_den;
    logic signed [32:0] r2_as_re, r2_as_im;
    // stage 3
    logic               r3_v;
    t_op                r3_op;
    logic               r3_neg_re, r3_neg_im;
    logic [63:0]        r3_mag_re, r3_mag_im;
    logic [63:0]        r3_den;
    logic               r3_dz;
    logic signed [32:0] r3_as_re, r3_as_im;
    // stage 4 and divider
    logic   r_dv [0:CAU_DIV_STEPS];
    t_stage r_dp [0:CAU_DIV_STEPS];
    t_stage n_d0;
    t_stage n_dp [1:CAU_DIV_STEPS];
    t_div_part w_sre [0:CAU_DIV_STEPS-1];
    t_div_part w_sim [0:CAU_DIV_STEPS-1];
    // output
    logic        r_ov;
    logic [31:0] r_ore, r_oim;
    t_status     r_ost;
    logic [31:0] n_ore, n_oim;
    t_status     n_ost;

    assign w_en        = !r_ov || o_rsp.ready;
    assign i_req.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r_ov <= 1'b0;
            for (int k = 0; k <= CAU_DIV_STEPS; k++) r_dv[k] <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_req.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r_dv[0] <= r3_v;
            for (int k = 1; k <= CAU_DIV_STEPS; k++) r_dv[k] <= r_dv[k-1];
            r_ov <= r_dv[CAU_DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_op  <= i_req.req_type;
            r1_prr <= 64'(i_req.a_re) * 64'(i_req.b_re);
            r1_pii <= 64'(i_req.a_im) * 64'(i_req.b_im);
            r1_pri <= 64'(i_req.a_re) * 64'(i_req.b_im);
            r1_pir <= 64'(i_req.a_im) * 64'(i_req.b_re);
            r1_brr <= 64'(i_req.b_re) * 64'(i_req.b_re);
            r1_bii <= 64'(i_req.b_im) * 64'(i_req.b_im);
            if (i_req.req_type == OP_SUB) begin
                r1_as_re <= 33'(i_req.a_re) - 33'(i_req.b_re);
                r1_as_im <= 33'(i_req.a_im) - 33'(i_req.b_im);
            end else begin
                r1_as_re <= 33'(i_req.a_re) + 33'(i_req.b_re);
                r1_as_im <= 33'(i_req.a_im) + 33'(i_req.b_im);
            end

            r2_op    <= r1_op;
            r2_as_re <= r1_as_re;
            r2_as_im <= r1_as_im;
            r2_den   <= r1_brr + r1_bii;
            if (r1_op == OP_MUL) begin
                r2_s_re <= 65'(r1_prr) - 65'(r1_pii);
                r2_s_im <= 65'(r1_pri) + 65'(r1_pir);
            end else begin
                r2_s_re <= 65'(r1_prr) + 65'(r1_pii);
                r2_s_im <= 65'(r1_pir) - 65'(r1_pri);
            end

            r3_op     <= r2_op;
            r3_as_re  <= r2_as_re;
            r3_as_im  <= r2_as_im;
            r3_den    <= r2_den;
            r3_dz     <= r2_den == 64'd0;
            r3_neg_re <= r2_s_re[64];
            r3_neg_im <= r2_s_im[64];
            r3_mag_re <= r2_s_re[64] ? 64'(-r2_s_re) : r2_s_re[63:0];
            r3_mag_im <= r2_s_im[64] ? 64'(-r2_s_im) : r2_s_im[63:0];

            r_dp[0] <= n_d0;
            for (int k = 1; k <= CAU_DIV_STEPS; k++) r_dp[k] <= n_dp[k];

            r_ore <= n_ore;
            r_oim <= n_oim;
            r_ost <= n_ost;
        end
    end

    // scale back, range check and divider setup
    always_comb begin
        logic [32:0] pre;
        logic [32:0] pim;
        logic [63:0] sre;
        logic [63:0] sim;
        n_d0        = '0;
        n_d0.op     = r3_op;
        n_d0.dz     = r3_dz;
        n_d0.neg_re = r3_neg_re;
        n_d0.neg_im = r3_neg_im;
        n_d0.den    = r3_den;
        sre         = r3_mag_re >> FRAC_BITS;
        sim         = r3_mag_im >> FRAC_BITS;
        pre         = f_pack(r3_neg_re, sre);
        pim         = f_pack(r3_neg_im, sim);
        case (r3_op)
            OP_ADD, OP_SUB: begin
                n_d0.res_re = (r3_as_re[32] != r3_as_re[31]) ?
                    (r3_as_re[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : r3_as_re[31:0];
                n_d0.res_im = (r3_as_im[32] != r3_as_im[31]) ?
                    (r3_as_im[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : r3_as_im[31:0];
                n_d0.sat = (r3_as_re[32] != r3_as_re[31]) || (r3_as_im[32] != r3_as_im[31]);
            end
            OP_MUL: begin
                n_d0.res_re = pre[31:0];
                n_d0.res_im = pim[31:0];
                n_d0.sat    = pre[32] || pim[32];
            end
            default: begin
                n_d0.res_re = '0;
                n_d0.res_im = '0;
                n_d0.sat    = 1'b0;
            end
        endcase
        n_d0.big_re  = {32'd0, r3_mag_re} >= ({32'd0, r3_den} << SH);
        n_d0.big_im  = {32'd0, r3_mag_im} >= ({32'd0, r3_den} << SH);
        n_d0.dre.rem = r3_mag_re >> SH;
        n_d0.dim.rem = r3_mag_im >> SH;
        n_d0.dre.nlo = 32'(r3_mag_re << FRAC_BITS);
        n_d0.dim.nlo = 32'(r3_mag_im << FRAC_BITS);
    end

    for (genvar g = 0; g < CAU_DIV_STEPS; g++) begin : g_div
        cau_div_step u_step (
            .i_den (r_dp[g].den),
            .i_re  (r_dp[g].dre),
            .i_im  (r_dp[g].dim),
            .o_re  (w_sre[g]),
            .o_im  (w_sim[g])
        );
    end

    // next divider stage words
    always_comb begin
        for (int k = 1; k <= CAU_DIV_STEPS; k++) begin
            n_dp[k]     = r_dp[k-1];
            n_dp[k].dre = w_sre[k-1];
            n_dp[k].dim = w_sim[k-1];
        end
    end

    // final packing
    always_comb begin
        t_stage      l;
        logic [32:0] qre;
        logic [32:0] qim;
        logic        sre;
        logic        sim;
        l   = r_dp[CAU_DIV_STEPS];
        qre = f_pack(l.neg_re, {32'd0, l.dre.q});
        qim = f_pack(l.neg_im, {32'd0, l.dim.q});
        sre = l.big_re || qre[32];
        sim = l.big_im || qim[32];
        if (l.op != OP_DIV) begin
            n_ore = l.res_re;
            n_oim = l.res_im;
            n_ost = l.sat ? ST_SAT : ST_OK;
        end else if (l.dz) begin
            n_ore = '0;
            n_oim = '0;
            n_ost = ST_DZ;
        end else begin
            n_ore = l.big_re ? (l.neg_re ? 32'h8000_0000 : 32'h7FFF_FFFF) : qre[31:0];
            n_oim = l.big_im ? (l.neg_im ? 32'h8000_0000 : 32'h7FFF_FFFF) : qim[31:0];
            n_ost = (sre || sim) ? ST_SAT : ST_OK;
        end
    end

    assign o_rsp.valid  = r_ov;
    assign o_rsp.res_re = r_ore;
    assign o_rsp.res_im = r_oim;
    assign o_rsp.status = r_ost;

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready == (!o_rsp.valid || o_rsp.ready))
        else $error("ready does not follow output stall");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_DZ) |-> (o_rsp.res_re == 0 && o_rsp.res_im == 0))
        else $error("divide by zero word carries nonzero parts");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.status == ST_OK || o_rsp.status == ST_SAT ||
                         o_rsp.status == ST_DZ))
        else $error("bad status code");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv[CAU_DIV_STEPS] && o_rsp.valid && !o_rsp.ready) |=> r_dv[CAU_DIV_STEPS])
        else $error("pipeline word lost during stall");

endmodule

@@ tb/tb_top.sv @@
// testbench for complex_arithmetic_unit: directed and random complex words with checking
// depends on cau_pkg, cau_if and the complex_arithmetic_unit rtl
`timescale 1ns / 1ps

module tb_top;
    import cau_pkg::*;

    localparam int FB = CAU_FRAC_BITS;
    localparam int WATCHDOG = 20000;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        t_status     st;
    } t_cplx_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    cau_req_if req_ch();
    cau_rsp_if rsp_ch();

    t_cplx_res pending_q[$];
    int errors = 0;
    int idle_cycles = 0;
    bit sending_done = 1'b0;

    complex_arithmetic_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = OP_ADD;
        req_ch.a_re = '0;
        req_ch.a_im = '0;
        req_ch.b_re = '0;
        req_ch.b_im = '0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // signed value in 66 bits to saturated 32 bits
    function automatic logic [31:0] clamp32(input logic signed [65:0] v, inout bit sat);
        if (v > 66'sd2147483647) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -66'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // truncating scale of a product sum
    function automatic logic signed [65:0] trunc_shift(input logic signed [65:0] v);
        logic [65:0] mag;
        mag = (v < 0) ? -v : v;
        mag = mag >> FB;
        return (v < 0) ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [65:0] trunc_div(input logic signed [65:0] num,
                                                     input logic [65:0] den);
        logic [97:0] mag;
        logic [97:0] q;
        mag = (num < 0) ? -num : num;
        q = (mag << FB) / den;
        if (q > 98'h1_0000_0000) q = 98'h1_0000_0000;
        return (num < 0) ? -$signed({1'b0, q[64:0]}) : $signed({1'b0, q[64:0]});
    endfunction

    function automatic t_cplx_res complex_result(input t_op op,
                                                 input logic signed [31:0] ar, ai, br, bi);
        t_cplx_res r;
        bit sat;
        logic signed [65:0] prr, pii, pri, pir, den;
        sat = 1'b0;
        r.st = ST_OK;
        prr = 66'(ar) * 66'(br);
        pii = 66'(ai) * 66'(bi);
        pri = 66'(ar) * 66'(bi);
        pir = 66'(ai) * 66'(br);
        case (op)
            OP_ADD: begin
                r.re = clamp32(66'(ar) + 66'(br), sat);
                r.im = clamp32(66'(ai) + 66'(bi), sat);
            end
            OP_SUB: begin
                r.re = clamp32(66'(ar) - 66'(br), sat);
                r.im = clamp32(66'(ai) - 66'(bi), sat);
            end
            OP_MUL: begin
                r.re = clamp32(trunc_shift(prr - pii), sat);
                r.im = clamp32(trunc_shift(pri + pir), sat);
            end
            default: begin
                den = 66'(br) * 66'(br) + 66'(bi) * 66'(bi);
                if (den == 0) begin
                    r.re = '0;
                    r.im = '0;
                    r.st = ST_DZ;
                end else begin
                    r.re = clamp32(trunc_div(prr + pii, den), sat);
                    r.im = clamp32(trunc_div(pir - pri, den), sat);
                end
            end
        endcase
        if (r.st == ST_OK && sat) r.st = ST_SAT;
        return r;
    endfunction

    task automatic send_word(input t_op op, input logic [31:0] ar, ai, br, bi);
        int g;
        g = gap_len();
        if (g > 0) begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= op;
        req_ch.a_re <= ar;
        req_ch.a_im <= ai;
        req_ch.b_re <= br;
        req_ch.b_im <= bi;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_q.push_back(complex_result(op, ar, ai, br, bi));
    endtask

    function automatic logic [31:0] rand_part();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(int'($urandom_range(0, 8)) - 4) << FB;
            3: return 32'(int'($urandom_range(0, 131071)) - 65536);
            4: return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_extremes();
        logic [31:0] ext[5];
        ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000, 32'hFFFF_FFFF};
        foreach (ext[i]) begin
            send_word(OP_ADD, ext[i], ext[i], ext[i], ext[i]);
            send_word(OP_SUB, ext[i], ext[4 - i], ext[4 - i], ext[i]);
            send_word(OP_MUL, ext[i], ext[i], ext[4 - i], ext[i]);
            send_word(OP_DIV, ext[i], ext[4 - i], ext[i], ext[4 - i]);
        end
    endtask

    task automatic test_div_by_zero();
        send_word(OP_DIV, 32'h0003_0000, 32'hFFFE_0000, 32'h0, 32'h0);
        send_word(OP_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
        send_word(OP_DIV, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h1);
    endtask

    task automatic test_random();
        t_op op;
        repeat (730) begin
            op = t_op'($urandom_range(0, 3));
            send_word(op, rand_part(), rand_part(), rand_part(), rand_part());
        end
    endtask

    // output stalls: ready stretches broken by random gaps
    initial begin : ready_gen
        int g;
        rsp_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            g = gap_len();
            if (g > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_cplx_res e;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_q.size() == 0) begin
                $error("result with no expectation: re %h im %h status %0d",
                       rsp_ch.res_re, rsp_ch.res_im, rsp_ch.status);
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (rsp_ch.res_re !== e.re) begin
                    $error("res_re expected %h actual %h", e.re, rsp_ch.res_re);
                    errors++;
                end
                if (rsp_ch.res_im !== e.im) begin
                    $error("res_im expected %h actual %h", e.im, rsp_ch.res_im);
                    errors++;
                end
                if (rsp_ch.status !== e.st) begin
                    $error("status expected %0d actual %0d", e.st, rsp_ch.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (sending_done && pending_q.size() == 0))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_div_by_zero();
        test_random();
        req_ch.valid <= 1'b0;
        sending_done = 1'b1;
        wait (pending_q.size() == 0);
        repeat (60) @(posedge i_clk);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
